// ===== rtl/sm83_alu_with_cb_ops_unit_defines.svh =====
// assertion macros for the checker file
`ifndef SM83_ALU_WITH_CB_OPS_UNIT_DEFINES_SVH
`define SM83_ALU_WITH_CB_OPS_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SM83_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sm83 alu check failed");

// next-cycle implication, disabled while reset is low
`define SM83_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sm83 alu check failed");

`endif

// ===== rtl/sm83_pkg.sv =====
// shared types and codes for the sm83 alu
package sm83_pkg;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef enum logic [4:0] {
        CMD_ADD  = 5'd0,
        CMD_ADC  = 5'd1,
        CMD_SUB  = 5'd2,
        CMD_SBC  = 5'd3,
        CMD_AND  = 5'd4,
        CMD_XOR  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_CP   = 5'd7,
        CMD_INC  = 5'd8,
        CMD_DEC  = 5'd9,
        CMD_DAA  = 5'd10,
        CMD_CPL  = 5'd11,
        CMD_SCF  = 5'd12,
        CMD_CCF  = 5'd13,
        CMD_RLCA = 5'd14,
        CMD_RRCA = 5'd15,
        CMD_RLA  = 5'd16,
        CMD_RRA  = 5'd17,
        CMD_CB   = 5'd18
    } t_cmd;

    typedef enum logic [1:0] {
        CB_SHIFT = 2'd0,
        CB_BIT   = 2'd1,
        CB_RES   = 2'd2,
        CB_SET   = 2'd3
    } t_cb_group;

    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift_kind;

    localparam logic [7:0] DAA_LIMIT   = 8'h99;
    localparam logic [3:0] DAA_NIB_MAX = 4'd9;
    localparam logic [3:0] DAA_ADJ     = 4'h6;

    typedef struct packed {
        logic [4:0] command;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [7:0] cb_opcode;
        logic [3:0] flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic [3:0] flags_out;
        logic       write_back;
    } t_alu_out;

endpackage

// ===== rtl/sm83_cb.sv =====
// cb-prefix group: rotates, shifts, swap, bit, res and set
module sm83_cb (
    input  logic [7:0]        i_operand,
    input  logic [7:0]        i_cb_opcode,
    input  logic [3:0]        i_flags,
    output sm83_pkg::t_alu_out o_res
);
    import sm83_pkg::*;

    logic [1:0] group_sel;
    logic [2:0] kind_sel;
    logic [7:0] mask;
    logic [7:0] sh_r;
    logic       sh_c;

    assign group_sel = i_cb_opcode[7:6];
    assign kind_sel  = i_cb_opcode[5:3];
    assign mask      = 8'd1 << kind_sel;

    always_comb begin
        case (kind_sel)
            SH_RLC: begin
                sh_c = i_operand[7];
                sh_r = {i_operand[6:0], i_operand[7]};
            end
            SH_RRC: begin
                sh_c = i_operand[0];
                sh_r = {i_operand[0], i_operand[7:1]};
            end
            SH_RL: begin
                sh_c = i_operand[7];
                sh_r = {i_operand[6:0], i_flags[FLAG_C]};
            end
            SH_RR: begin
                sh_c = i_operand[0];
                sh_r = {i_flags[FLAG_C], i_operand[7:1]};
            end
            SH_SLA: begin
                sh_c = i_operand[7];
                sh_r = {i_operand[6:0], 1'b0};
            end
            SH_SRA: begin
                sh_c = i_operand[0];
                sh_r = {i_operand[7], i_operand[7:1]};
            end
            SH_SWAP: begin
                sh_c = 1'b0;
                sh_r = {i_operand[3:0], i_operand[7:4]};
            end
            default: begin
                sh_c = i_operand[0];
                sh_r = {1'b0, i_operand[7:1]};
            end
        endcase
    end

    always_comb begin
        case (group_sel)
            CB_BIT: begin
                o_res.result     = i_operand;
                o_res.flags_out  = {~|(i_operand & mask), 1'b0, 1'b1, i_flags[FLAG_C]};
                o_res.write_back = 1'b0;
            end
            CB_RES: begin
                o_res.result     = i_operand & ~mask;
                o_res.flags_out  = i_flags;
                o_res.write_back = 1'b1;
            end
            CB_SET: begin
                o_res.result     = i_operand | mask;
                o_res.flags_out  = i_flags;
                o_res.write_back = 1'b1;
            end
            default: begin
                o_res.result     = sh_r;
                o_res.flags_out  = {~|sh_r, 1'b0, 1'b0, sh_c};
                o_res.write_back = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/sm83_core.sv =====
// combinational alu datapath between the input and result registers
module sm83_core (
    input  sm83_pkg::t_alu_in  i_item,
    output sm83_pkg::t_alu_out o_res
);
    import sm83_pkg::*;

    logic [7:0] a;
    logic [7:0] b;
    logic [3:0] f;
    logic       cin;
    logic       use_carry;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] dif9;
    logic [4:0] dif_lo;
    logic [7:0] inc_r;
    logic [7:0] dec_r;
    logic       daa_lo;
    logic       daa_hi;
    logic [7:0] daa_u;
    logic [7:0] daa_r;
    t_alu_out   cb_res;

    assign a   = i_item.operand_a;
    assign b   = i_item.operand_b;
    assign f   = i_item.flags_in;
    assign cin = f[FLAG_C];

    assign use_carry = (i_item.command == CMD_ADC) || (i_item.command == CMD_SBC);

    assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, use_carry & cin};
    assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_carry & cin};
    assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, use_carry & cin};
    assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_carry & cin};

    assign inc_r = a + 8'd1;
    assign dec_r = a - 8'd1;

    assign daa_lo = f[FLAG_H] || (!f[FLAG_N] && (a[3:0] > DAA_NIB_MAX));
    assign daa_hi = cin || (!f[FLAG_N] && (a > DAA_LIMIT));
    assign daa_u  = {(daa_hi ? DAA_ADJ : 4'd0), (daa_lo ? DAA_ADJ : 4'd0)};
    assign daa_r  = f[FLAG_N] ? (a - daa_u) : (a + daa_u);

    sm83_cb u_cb (
        .i_operand   (a),
        .i_cb_opcode (i_item.cb_opcode),
        .i_flags     (f),
        .o_res       (cb_res)
    );

    always_comb begin
        o_res.result     = a;
        o_res.flags_out  = f;
        o_res.write_back = 1'b1;
        case (i_item.command)
            CMD_ADD, CMD_ADC: begin
                o_res.result    = sum9[7:0];
                o_res.flags_out = {~|sum9[7:0], 1'b0, sum_lo[4], sum9[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                o_res.result     = dif9[7:0];
                o_res.flags_out  = {~|dif9[7:0], 1'b1, dif_lo[4], dif9[8]};
                o_res.write_back = (i_item.command != CMD_CP);
            end
            CMD_AND: begin
                o_res.result    = a & b;
                o_res.flags_out = {~|(a & b), 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR: begin
                o_res.result    = a ^ b;
                o_res.flags_out = {~|(a ^ b), 3'b000};
            end
            CMD_OR: begin
                o_res.result    = a | b;
                o_res.flags_out = {~|(a | b), 3'b000};
            end
            CMD_INC: begin
                o_res.result    = inc_r;
                o_res.flags_out = {~|inc_r, 1'b0, ~|inc_r[3:0], cin};
            end
            CMD_DEC: begin
                o_res.result    = dec_r;
                o_res.flags_out = {~|dec_r, 1'b1, &dec_r[3:0], cin};
            end
            CMD_DAA: begin
                o_res.result    = daa_r;
                o_res.flags_out = {~|daa_r, f[FLAG_N], 1'b0, daa_hi};
            end
            CMD_CPL: begin
                o_res.result    = ~a;
                o_res.flags_out = {f[FLAG_Z], 1'b1, 1'b1, cin};
            end
            CMD_SCF: begin
                o_res.flags_out  = {f[FLAG_Z], 1'b0, 1'b0, 1'b1};
                o_res.write_back = 1'b0;
            end
            CMD_CCF: begin
                o_res.flags_out  = {f[FLAG_Z], 1'b0, 1'b0, ~cin};
                o_res.write_back = 1'b0;
            end
            CMD_RLCA: begin
                o_res.result    = {a[6:0], a[7]};
                o_res.flags_out = {3'b000, a[7]};
            end
            CMD_RRCA: begin
                o_res.result    = {a[0], a[7:1]};
                o_res.flags_out = {3'b000, a[0]};
            end
            CMD_RLA: begin
                o_res.result    = {a[6:0], cin};
                o_res.flags_out = {3'b000, a[7]};
            end
            CMD_RRA: begin
                o_res.result    = {cin, a[7:1]};
                o_res.flags_out = {3'b000, a[0]};
            end
            CMD_CB: begin
                o_res = cb_res;
            end
            default: begin
                o_res.write_back = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/sm83_alu_with_cb_ops_unit.sv =====
// top level: sm83 alu with cb group, input register and result register
//
// input channel: i_in_valid / o_in_ready carry one operation (command,
// operands, cb opcode, incoming flags) in i_in_data.
// output channel: o_out_valid / i_out_ready carry the result byte, new
// flags and the write-back strobe in o_out_data.
// every transfer in gives exactly one transfer out, in order.
// the path runs from the input transfer through the input register, then
// through the alu into the result register, which drives o_out_valid.
// throughput: one operation per cycle while the receiver does not stall,
// set by the single-pass datapath between the two registers.
// when the receiver stalls, the result register holds its item and the
// input register keeps one more; o_in_ready drops only when both are full.
// o_in_ready follows i_out_ready combinationally.
// reset (i_rst_n low, synchronous) empties both registers; no state is
// kept between operations.
module sm83_alu_with_cb_ops_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sm83_pkg::t_alu_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sm83_pkg::t_alu_out o_out_data
);
    import sm83_pkg::*;

    logic     r_s1_valid;
    logic     n_s1_valid;
    t_alu_in  r_s1_data;
    logic     r_out_valid;
    logic     n_out_valid;
    t_alu_out r_out_data;
    t_alu_out core_res;
    logic     out_free;
    logic     in_xfer;
    logic     s1_move;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign s1_move    = r_s1_valid && out_free;

    sm83_core u_core (
        .i_item (r_s1_data),
        .o_res  (core_res)
    );

    always_comb begin
        n_s1_valid  = o_in_ready ? i_in_valid : r_s1_valid;
        n_out_valid = out_free ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= i_in_data;
        end
        if (s1_move) begin
            r_out_data <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/sm83_chk.sv =====
// port checker for the sm83 alu top level, with its bind
`include "sm83_alu_with_cb_ops_unit_defines.svh"

module sm83_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sm83_pkg::t_alu_out o_out_data
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    `SM83_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid)
    `SM83_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(o_out_data))
    `SM83_ASSERT_NOW(a_ready_when_draining, i_clk, i_rst_n, !out_stall, o_in_ready)
    `SM83_ASSERT_NOW(a_two_cycle_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(in_xfer, 2))

endmodule

bind sm83_alu_with_cb_ops_unit sm83_chk u_sm83_chk (.*);
